// File: rtl/core/assert_macros.svh
// Assertion macros shared by the line stamper RTL.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that implies another at the same clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/crcls_pkg.sv
// Package for the CRC-tagged line stamper: codeword constants, region and
// register codes, the configuration record and the CRC-8 byte step.
package crcls_pkg;

    localparam int SYNC_LEN    = 4;
    localparam int CRC_LEN     = 8;
    localparam int CRC_BYTES   = 8;
    localparam int CRC_CALC_W  = CRC_BYTES * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_WORD_W  = 32;
    localparam int CELL_W      = 8;
    localparam int PAD_W       = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CRC_LEN-1:0] CRC_POLY   = 8'h2F;
    localparam logic [CRC_LEN-1:0] CRC_INIT   = 8'hFF;
    localparam logic [CRC_LEN-1:0] CRC_XOROUT = 8'hFF;

    typedef enum logic [1:0] {
        REGION_IDLE = 2'd0,
        REGION_CELL = 2'd1,
        REGION_PAD  = 2'd2
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN = 3'd0,
        CFG_CELL_WIDTH   = 3'd1,
        CFG_PAD_LENGTH   = 3'd2,
        CFG_ONE_WORD     = 3'd3,
        CFG_ZERO_WORD    = 3'd4,
        CFG_PAD_WORD     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [SYNC_LEN-1:0]   sync_pattern;
        logic [CELL_W-1:0]     cell_width;
        logic [PAD_W-1:0]      pad_length;
        logic [CFG_WORD_W-1:0] one_word;
        logic [CFG_WORD_W-1:0] zero_word;
        logic [CFG_WORD_W-1:0] pad_word;
    } t_cfg;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [CRC_LEN-1:0] crc8_byte(input logic [CRC_LEN-1:0] crc_in,
                                                     input logic [7:0] data);
        logic [CRC_LEN-1:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_LEN-1]) begin
                c = {c[CRC_LEN-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_LEN-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/crcls_if.sv
// Handshake interfaces of the line stamper: input items, result words and
// configuration writes. Uses crcls_pkg for the register port widths.
interface crcls_in_if #(parameter int PAYLOAD_WIDTH = 64);
    logic                     valid;
    logic                     ready;
    logic                     start_line;
    logic [PAYLOAD_WIDTH-1:0] payload;
    modport source (output valid, output start_line, output payload, input ready);
    modport sink (input valid, input start_line, input payload, output ready);
endinterface

interface crcls_out_if #(parameter int WORD_BITS = 32);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] pixel_word;
    logic [1:0]           region;
    logic                 bit_value;
    logic                 last_word;
    modport source (output valid, output pixel_word, output region, output bit_value,
                    output last_word, input ready);
    modport sink (input valid, input pixel_word, input region, input bit_value,
                  input last_word, output ready);
endinterface

interface crcls_cfg_if import crcls_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/crcls_front.sv
// Front end of the line stamper: accepts input beats and holds them in a
// short queue for the back end. Depends on crcls_pkg and crcls_in_if.
`include "assert_macros.svh"

module crcls_front import crcls_pkg::*; #(
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    crcls_in_if.sink                 i_in,
    output logic                     o_head_valid,
    output logic                     o_head_start,
    output logic [PAYLOAD_WIDTH-1:0] o_head_payload,
    input  logic                     i_pop
);

    logic                     r_start   [QUEUE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_payload [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        r_wr_ptr;
    logic [QPTR_W-1:0]        r_rd_ptr;
    logic [QCNT_W-1:0]        r_count;
    logic [QCNT_W-1:0]        n_count;
    logic                     w_push;

    assign i_in.ready     = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push         = i_in.valid && i_in.ready;
    assign o_head_valid   = (r_count != '0);
    assign o_head_start   = r_start[r_rd_ptr];
    assign o_head_payload = r_payload[r_rd_ptr];

    always_comb begin
        unique case ({w_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_start[r_wr_ptr]   <= i_in.start_line;
            r_payload[r_wr_ptr] <= i_in.payload;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH),
        "queue count exceeds depth")
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0,
        "pop from an empty queue")

endmodule

// File: rtl/core/crcls_crc8.sv
// Iterative CRC-8 unit: one payload byte per cycle, eight bytes per payload.
// Depends on crcls_pkg for the polynomial and the byte step.
module crcls_crc8 import crcls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CRC_CALC_W-1:0] i_data,
    output logic [CRC_LEN-1:0]    o_crc,
    output logic                  o_busy
);

    localparam int LEFT_W = $clog2(CRC_BYTES + 1);

    logic [CRC_LEN-1:0]    r_crc;
    logic [CRC_CALC_W-1:0] r_data;
    logic [LEFT_W-1:0]     r_left;

    assign o_busy = (r_left != '0);
    assign o_crc  = r_crc ^ CRC_XOROUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_crc  <= '0;
        end else if (i_start) begin
            r_left <= LEFT_W'(CRC_BYTES);
            r_crc  <= CRC_INIT;
        end else if (o_busy) begin
            r_left <= r_left - LEFT_W'(1);
            r_crc  <= crc8_byte(r_crc, r_data[CRC_CALC_W-1 -: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_data <= i_data;
        end else if (o_busy) begin
            r_data <= {r_data[CRC_CALC_W-9:0], 8'h00};
        end
    end

endmodule

// File: rtl/core/crcls_back.sv
// Back end of the line stamper: walks the codeword cells and pad words, one
// queued beat per result, into an output register. Uses crcls_pkg, crcls_crc8.
`include "assert_macros.svh"

module crcls_back import crcls_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_head_valid,
    input  logic                     i_head_start,
    input  logic [PAYLOAD_WIDTH-1:0] i_head_payload,
    output logic                     o_pop,
    crcls_out_if.source              o_out
);

    localparam int HEAD_LEN = SYNC_LEN + PAYLOAD_WIDTH;
    localparam int CODE_LEN = HEAD_LEN + CRC_LEN;
    localparam int POS_W    = $clog2(CODE_LEN + 1);

    logic [HEAD_LEN-1:0]   r_code,   n_code,   s_code;
    logic [POS_W-1:0]      r_pos,    n_pos,    s_pos;
    logic [CELL_W-1:0]     r_cell,   n_cell,   s_cell;
    logic [PAD_W-1:0]      r_pad,    n_pad,    s_pad;
    logic                  r_active, n_active, s_active;

    logic                  r_out_valid;
    logic [CFG_WORD_W-1:0] r_word,   n_word;
    t_region               r_region, n_region;
    logic                  r_bit,    n_bit;
    logic                  r_last,   n_last;

    logic [CRC_LEN-1:0]    w_crc;
    logic                  w_crc_busy;
    logic                  w_crc_load;
    logic [CELL_W:0]       w_cell_eff;

    assign o_pop = i_head_valid && (!r_out_valid || o_out.ready);
    assign w_cell_eff = (i_cfg.cell_width == '0) ? (CELL_W + 1)'(1) : {1'b0, i_cfg.cell_width};

    crcls_crc8 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop && i_head_start),
        .i_data  (CRC_CALC_W'(i_head_payload)),
        .o_crc   (w_crc),
        .o_busy  (w_crc_busy)
    );

    always_comb begin
        s_code   = r_code;
        s_pos    = r_pos;
        s_cell   = r_cell;
        s_pad    = r_pad;
        s_active = r_active;
        if (i_head_start) begin
            s_code   = {i_cfg.sync_pattern, i_head_payload};
            s_pos    = '0;
            s_cell   = '0;
            s_pad    = '0;
            s_active = 1'b1;
        end

        n_code     = s_code;
        n_pos      = s_pos;
        n_cell     = s_cell;
        n_pad      = s_pad;
        n_active   = s_active;
        n_word     = i_cfg.pad_word;
        n_region   = REGION_IDLE;
        n_bit      = 1'b0;
        n_last     = 1'b0;
        w_crc_load = 1'b0;

        if (s_active) begin
            if (s_pos < POS_W'(CODE_LEN)) begin
                n_bit    = s_code[HEAD_LEN-1];
                n_word   = n_bit ? i_cfg.one_word : i_cfg.zero_word;
                n_region = REGION_CELL;
                if ({1'b0, s_cell} + (CELL_W + 1)'(1) >= w_cell_eff) begin
                    n_cell = '0;
                    n_pos  = s_pos + POS_W'(1);
                    n_code = {s_code[HEAD_LEN-2:0], 1'b0};
                    if (n_pos == POS_W'(HEAD_LEN)) begin
                        n_code[HEAD_LEN-1 -: CRC_LEN] = w_crc;
                        w_crc_load = 1'b1;
                    end
                    if (n_pos >= POS_W'(CODE_LEN) && i_cfg.pad_length == '0) begin
                        n_last   = 1'b1;
                        n_active = 1'b0;
                    end
                end else begin
                    n_cell = s_cell + CELL_W'(1);
                end
            end else begin
                n_region = REGION_PAD;
                if ({1'b0, s_pad} + (PAD_W + 1)'(1) >= {1'b0, i_cfg.pad_length}) begin
                    n_last   = 1'b1;
                    n_active = 1'b0;
                end else begin
                    n_pad = s_pad + PAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= '0;
            r_pos       <= '0;
            r_cell      <= '0;
            r_pad       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_code      <= n_code;
            r_pos       <= n_pos;
            r_cell      <= n_cell;
            r_pad       <= n_pad;
            r_active    <= n_active;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word   <= n_word;
            r_region <= n_region;
            r_bit    <= n_bit;
            r_last   <= n_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_word = WORD_BITS'(r_word);
    assign o_out.region     = r_region;
    assign o_out.bit_value  = r_bit;
    assign o_out.last_word  = r_last;

    `ASSERT_IMPLIES(a_crc_ready, i_clk, i_rst_n, o_pop && w_crc_load, !w_crc_busy,
        "CRC taken into the codeword before it is complete")
    `ASSERT_IMPLIES(a_idle_quiet, i_clk, i_rst_n,
        r_out_valid && r_region == REGION_IDLE, !r_last && !r_bit,
        "idle word carries a cell bit or a line end")

endmodule

// File: rtl/core/crc_tagged_bit_cell_line_stamper.sv
// Top level of the CRC-tagged line stamper: configuration registers, front
// queue and back end. Depends on crcls_pkg, crcls_if, crcls_front, crcls_back.
//
// Channels: i_in carries one beat per output word (start_line, payload);
// o_out returns one beat per input beat (pixel_word, region, bit_value,
// last_word); i_cfg writes the six registers by index and is always ready.
// A beat with start_line high latches the payload and the sync nibble and
// starts a line: sync nibble, payload and CRC-8 are sent MSB first, each bit
// as cell_width words, then pad_length pad words. Beats outside a line give
// the pad word with region idle.
// A beat accepted into the front queue is registered in the back end's output
// register and then shown on o_out. Throughput: one beat per cycle while o_out
// is ready, set by the cell sequencer in the back end; the CRC runs one byte per
// cycle beside it and is done long before its bits are sent.
// Reset (synchronous, active low) loads the register defaults, empties the
// queue and leaves the line idle. When o_out stalls, the output register
// holds its beat and the two-entry queue fills, then i_in drops ready.
module crc_tagged_bit_cell_line_stamper import crcls_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crcls_in_if.sink    i_in,
    crcls_out_if.source o_out,
    crcls_cfg_if.sink   i_cfg
);

    t_cfg                     r_cfg;
    logic                     w_head_valid;
    logic                     w_head_start;
    logic [PAYLOAD_WIDTH-1:0] w_head_payload;
    logic                     w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern <= '0;
            r_cfg.cell_width   <= CELL_W'(1);
            r_cfg.pad_length   <= '0;
            r_cfg.one_word     <= '1;
            r_cfg.zero_word    <= '0;
            r_cfg.pad_word     <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SYNC_PATTERN: r_cfg.sync_pattern <= i_cfg.data[SYNC_LEN-1:0];
                CFG_CELL_WIDTH:   r_cfg.cell_width   <= i_cfg.data[CELL_W-1:0];
                CFG_PAD_LENGTH:   r_cfg.pad_length   <= i_cfg.data[PAD_W-1:0];
                CFG_ONE_WORD:     r_cfg.one_word     <= i_cfg.data[CFG_WORD_W-1:0];
                CFG_ZERO_WORD:    r_cfg.zero_word    <= i_cfg.data[CFG_WORD_W-1:0];
                CFG_PAD_WORD:     r_cfg.pad_word     <= i_cfg.data[CFG_WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    crcls_front #(
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .o_head_valid   (w_head_valid),
        .o_head_start   (w_head_start),
        .o_head_payload (w_head_payload),
        .i_pop          (w_pop)
    );

    crcls_back #(
        .WORD_BITS     (WORD_BITS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head_valid   (w_head_valid),
        .i_head_start   (w_head_start),
        .i_head_payload (w_head_payload),
        .o_pop          (w_pop),
        .o_out          (o_out)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for crc_tagged_bit_cell_line_stamper: drives item beats and register
// writes, predicts every pixel beat (cells, CRC-8 tag, pad, idle) and compares field by field.
// Depends on crcls_pkg, the crcls interfaces and the line stamper RTL.
module testbench;
    import crcls_pkg::*;

    localparam int WORD_BITS     = 32;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int CODE_LEN      = SYNC_LEN + PAYLOAD_WIDTH + CRC_LEN;
    localparam int RANDOM_BEATS  = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        t_region              region;
        logic                 bit_value;
        logic                 last_word;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crcls_in_if #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) item_bus ();
    crcls_out_if #(.WORD_BITS(WORD_BITS)) pixel_bus ();
    crcls_cfg_if reg_bus ();

    crc_tagged_bit_cell_line_stamper #(
        .WORD_BITS(WORD_BITS),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(item_bus.sink),
        .o_out(pixel_bus.source),
        .i_cfg(reg_bus.sink)
    );

    t_cfg                reg_shadow;
    logic [CODE_LEN-1:0] line_code;
    int unsigned         code_pos;
    int unsigned         cell_pos;
    int unsigned         pad_pos;
    bit                  line_on;

    t_pixel pending_pixels[$];
    t_pixel want_pixel;
    int     mismatch_count = 0;
    int     checked_beats = 0;
    bit     src_gaps_on = 1'b1;
    bit     sink_stalls_on = 1'b1;
    int     hold_req_id = 0;
    int     hold_req_len = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [CRC_LEN-1:0] crc8_autosar(input logic [PAYLOAD_WIDTH-1:0] data);
        logic [CRC_LEN-1:0] acc;
        logic               fb;
        acc = CRC_INIT;
        for (int i = PAYLOAD_WIDTH - 1; i >= 0; i--) begin
            fb = acc[CRC_LEN-1] ^ data[i];
            acc = {acc[CRC_LEN-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return acc ^ CRC_XOROUT;
    endfunction

    function automatic t_pixel stamp_pixel(input logic start, input logic [PAYLOAD_WIDTH-1:0] data);
        t_pixel      px;
        int unsigned width;
        px.word = reg_shadow.pad_word[WORD_BITS-1:0];
        px.region = REGION_IDLE;
        px.bit_value = 1'b0;
        px.last_word = 1'b0;
        if (start) begin
            line_code = {reg_shadow.sync_pattern, data, crc8_autosar(data)};
            code_pos = 0;
            cell_pos = 0;
            pad_pos = 0;
            line_on = 1'b1;
        end
        if (line_on) begin
            if (code_pos < CODE_LEN) begin
                width = (reg_shadow.cell_width == 0) ? 1 : reg_shadow.cell_width;
                px.bit_value = line_code[CODE_LEN-1-code_pos];
                px.word = px.bit_value ? reg_shadow.one_word[WORD_BITS-1:0]
                                       : reg_shadow.zero_word[WORD_BITS-1:0];
                px.region = REGION_CELL;
                if (cell_pos + 1 >= width) begin
                    cell_pos = 0;
                    code_pos++;
                    if (code_pos >= CODE_LEN && reg_shadow.pad_length == 0) begin
                        px.last_word = 1'b1;
                        line_on = 1'b0;
                    end
                end else begin
                    cell_pos++;
                end
            end else begin
                px.region = REGION_PAD;
                if (pad_pos + 1 >= reg_shadow.pad_length) begin
                    px.last_word = 1'b1;
                    line_on = 1'b0;
                end else begin
                    pad_pos++;
                end
            end
        end
        return px;
    endfunction

    function automatic int line_beats();
        return CODE_LEN * ((reg_shadow.cell_width == 0) ? 1 : reg_shadow.cell_width)
               + reg_shadow.pad_length;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [PAYLOAD_WIDTH-1:0] random_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("beat %0d %s: expected %h, got %h", checked_beats, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pixel_bus.valid && pixel_bus.ready) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch("unexpected beat, pixel_word", '0, pixel_bus.pixel_word);
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (pixel_bus.pixel_word !== want_pixel.word) begin
                    note_mismatch("pixel_word", want_pixel.word, pixel_bus.pixel_word);
                end
                if (pixel_bus.region !== want_pixel.region) begin
                    note_mismatch("region", want_pixel.region, pixel_bus.region);
                end
                if (pixel_bus.bit_value !== want_pixel.bit_value) begin
                    note_mismatch("bit_value", want_pixel.bit_value, pixel_bus.bit_value);
                end
                if (pixel_bus.last_word !== want_pixel.last_word) begin
                    note_mismatch("last_word", want_pixel.last_word, pixel_bus.last_word);
                end
            end
            checked_beats++;
        end
    end

    initial begin : ready_driver
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left = 0;
        hold_seen = 0;
        pixel_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req_id != hold_seen) begin
                hold_seen = hold_req_id;
                hold_left = hold_req_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                pixel_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pixel_bus.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
                stall_left = idle_len() - 1;
                pixel_bus.ready <= 1'b0;
            end else begin
                pixel_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic start, input logic [PAYLOAD_WIDTH-1:0] data);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            item_bus.start_line <= 1'($urandom_range(0, 1));
            item_bus.payload <= random_payload();
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.start_line <= start;
        item_bus.payload <= data;
        do @(posedge i_clk); while (!item_bus.ready);
        pending_pixels.push_back(stamp_pixel(start, data));
    endtask

    task automatic send_cont(input int count);
        repeat (count) send_beat(1'b0, random_payload());
    endtask

    task automatic run_line(input logic [PAYLOAD_WIDTH-1:0] data, input int tail);
        send_beat(1'b1, data);
        send_cont(line_beats() - 1 + tail);
    endtask

    task automatic quiesce();
        item_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data <= data;
        do @(posedge i_clk); while (!reg_bus.ready);
        case (idx)
            CFG_SYNC_PATTERN: reg_shadow.sync_pattern = data[SYNC_LEN-1:0];
            CFG_CELL_WIDTH:   reg_shadow.cell_width = data[CELL_W-1:0];
            CFG_PAD_LENGTH:   reg_shadow.pad_length = data[PAD_W-1:0];
            CFG_ONE_WORD:     reg_shadow.one_word = data[CFG_WORD_W-1:0];
            CFG_ZERO_WORD:    reg_shadow.zero_word = data[CFG_WORD_W-1:0];
            CFG_PAD_WORD:     reg_shadow.pad_word = data[CFG_WORD_W-1:0];
            default: ;
        endcase
        reg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_idle_after_reset();
        send_cont(4);
        quiesce();
    endtask

    task automatic test_default_line();
        run_line('1, 2);
        quiesce();
    endtask

    // Extreme register values, a zero cell width taking effect inside a cell and the pad
    // length cut to zero while the pad is running.
    task automatic test_register_extremes();
        write_reg(CFG_SYNC_PATTERN, '1);
        write_reg(CFG_CELL_WIDTH, '1);
        write_reg(CFG_PAD_LENGTH, '1);
        write_reg(CFG_ONE_WORD, '0);
        write_reg(CFG_ZERO_WORD, '1);
        write_reg(CFG_PAD_WORD, $urandom);
        send_beat(1'b1, '0);
        send_cont(300);
        quiesce();
        write_reg(CFG_CELL_WIDTH, 0);
        send_cont(CODE_LEN - 1 + 20);
        quiesce();
        write_reg(CFG_PAD_LENGTH, 0);
        send_cont(3);
        quiesce();
    endtask

    task automatic test_restart_mid_line();
        write_reg(CFG_SYNC_PATTERN, 32'hA);
        write_reg(CFG_CELL_WIDTH, 2);
        write_reg(CFG_PAD_LENGTH, 10);
        write_reg(CFG_ONE_WORD, $urandom);
        write_reg(CFG_ZERO_WORD, $urandom);
        write_reg(CFG_PAD_WORD, $urandom);
        send_beat(1'b1, random_payload());
        send_cont(30);
        send_beat(1'b1, random_payload());
        send_cont(CODE_LEN * 2 + 6 - 1);
        quiesce();
        write_reg(CFG_PAD_LENGTH, 3);
        send_cont(3);
        quiesce();
    endtask

    task automatic test_unused_register_index();
        for (int i = CFG_PAD_WORD + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_reg(CFG_IDX_W'(i), $urandom);
        end
        run_line(random_payload(), 2);
        quiesce();
    endtask

    task automatic test_output_backpressure();
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        write_reg(CFG_CELL_WIDTH, 1);
        write_reg(CFG_PAD_LENGTH, 4);
        hold_req_len = HOLD_CYCLES;
        hold_req_id++;
        run_line(random_payload(), 0);
        quiesce();
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_random_lines();
        int sent;
        int len;
        int pick;
        int width;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            quiesce();
            src_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            width = (pick < 6) ? 1 : (pick < 9) ? $urandom_range(2, 4) : 0;
            write_reg(CFG_SYNC_PATTERN, $urandom);
            write_reg(CFG_CELL_WIDTH, width);
            write_reg(CFG_PAD_LENGTH, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            write_reg(CFG_ONE_WORD, $urandom);
            write_reg(CFG_ZERO_WORD, $urandom);
            write_reg(CFG_PAD_WORD, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 40);
                send_cont(len);
                sent += len;
            end
            repeat ($urandom_range(1, 3)) begin
                len = line_beats();
                if ($urandom_range(0, 9) < 7) begin
                    len = len + $urandom_range(0, 3);
                end else begin
                    len = $urandom_range(1, len - 1);
                end
                send_beat(1'b1, random_payload());
                send_cont(len - 1);
                sent += len;
            end
        end
        quiesce();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.start_line <= 1'b0;
        item_bus.payload <= '0;
        reg_bus.valid <= 1'b0;
        reg_bus.index <= CFG_SYNC_PATTERN;
        reg_bus.data <= '0;
        reg_shadow.sync_pattern = '0;
        reg_shadow.cell_width = CELL_W'(1);
        reg_shadow.pad_length = '0;
        reg_shadow.one_word = '1;
        reg_shadow.zero_word = '0;
        reg_shadow.pad_word = '0;
        line_code = '0;
        code_pos = 0;
        cell_pos = 0;
        pad_pos = 0;
        line_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_default_line();
        test_register_extremes();
        test_restart_mid_line();
        test_unused_register_index();
        test_output_backpressure();
        test_random_lines();

        quiesce();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
